// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant check failed");

`endif

// ----- src/aph_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aph_pkg;

	localparam int SINE_DEPTH     = 256;
	localparam int SINE_ADDR_BITS = $clog2(SINE_DEPTH);
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int DIV_STEPS      = 31;

	localparam logic [15:0] SWEEP_MIN_RST = 16'd1201;
	localparam logic [15:0] SWEEP_MAX_RST = 16'd4369;
	localparam logic [31:0] LFO_STEP_RST  = 32'd44739;
	localparam logic [15:0] FEEDBACK_RST  = 16'd45875;
	localparam logic [16:0] WET_DEPTH_RST = 17'd65536;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SWEEP_MIN = 3'd0,
		CFG_SWEEP_MAX = 3'd1,
		CFG_LFO_STEP  = 3'd2,
		CFG_FEEDBACK  = 3'd3,
		CFG_WET_DEPTH = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DMUL,
		S_DSUM,
		S_DIVGO,
		S_FBMUL,
		S_FBSUM,
		S_DIVWAIT,
		S_AXMUL,
		S_Y,
		S_AYMUL,
		S_Z,
		S_WMUL,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_D,
		MUL_FB,
		MUL_AX,
		MUL_AY,
		MUL_WET
	} mul_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     accept;
		mul_sel_t mul_sel;
		logic     load_d;
		logic     div_start;
		logic     load_x0;
		logic     load_y;
		logic     load_z;
		logic     load_out;
	} aph_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic last_stage;
		logic out_free;
	} aph_status_t;

	typedef logic [16:0] sine_rom_t [SINE_DEPTH];

	// Quarter-wave sine in Q1.16, odd Horner polynomial through x^11 in Q30.
	function automatic sine_rom_t gen_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			x  = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			t  = Q30_ONE - x2 / 110;
			t  = Q30_ONE - ((x2 * t) >> 30) / 72;
			t  = Q30_ONE - ((x2 * t) >> 30) / 42;
			t  = Q30_ONE - ((x2 * t) >> 30) / 20;
			t  = Q30_ONE - ((x2 * t) >> 30) / 6;
			s  = (x * t) >> 30;
			s  = (s + 64'd8192) >> 14;
			rom[k] = (s > 64'd65536) ? 17'd65536 : s[16:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = gen_sine_rom();

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (v < -68'sd2147483648) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- src/aph_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Rounded coefficient a = round(((2^32 - d) << 30) / (2^32 + d)), restoring
// division, one quotient bit per cycle.
module aph_divider
	import aph_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] d,
	output logic             busy,
	output logic [30:0]      quot
);

	localparam int CNT_BITS = $clog2(DIV_STEPS);

	logic [32:0]         den_q;
	logic [32:0]         rem_q;
	logic [30:0]         sh_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;

	logic [32:0] den_start;
	logic [32:0] one_minus;
	logic [62:0] dividend;
	logic [33:0] trial;
	logic [33:0] diff;
	logic        ge;

	assign den_start = {1'b1, d};
	assign one_minus = 33'h1_0000_0000 - {1'b0, d};
	// half the divisor added for round-to-nearest
	assign dividend  = {one_minus, 30'b0} + {31'b0, den_start[32:1]};

	assign trial = {rem_q, sh_q[30]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = ~diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den_start;
			rem_q <= {1'b0, dividend[62:31]};
			sh_q  <= dividend[30:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[32:0] : trial[32:0];
			sh_q  <= {sh_q[29:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = sh_q;

	`ASSERT_IMPL(a_rem_below_den, clk, arst_n, busy_q, rem_q < den_q)
	`ASSERT_IMPL(a_quot_range, clk, arst_n, $fell(busy_q), sh_q <= 31'h4000_0000)

endmodule

`default_nettype wire

// ----- src/aph_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aph_datapath
	import aph_pkg::*;
#(
	parameter int NUM_STAGES  = 6,
	parameter int SAMPLE_BITS = 24,
	parameter int TDATA_BITS  = 24
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire aph_cmd_t                  cmd,
	output aph_status_t                    status,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	input  wire logic [TDATA_BITS-1:0]     in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [TDATA_BITS-1:0]          out_data
);

	localparam int STAGE_BITS = $clog2(NUM_STAGES);
	localparam logic signed [67:0] SMAX = (68'sd1 <<< (SAMPLE_BITS - 1)) - 68'sd1;
	localparam logic signed [67:0] SMIN = -SMAX - 68'sd1;

	function automatic logic [SAMPLE_BITS-1:0] sat_s(input logic signed [67:0] v);
		if (v > SMAX) begin
			return SMAX[SAMPLE_BITS-1:0];
		end else if (v < SMIN) begin
			return SMIN[SAMPLE_BITS-1:0];
		end else begin
			return v[SAMPLE_BITS-1:0];
		end
	endfunction

	// configuration
	logic [15:0] sweep_min_q;
	logic [15:0] sweep_max_q;
	logic [31:0] lfo_step_q;
	logic [15:0] feedback_q;
	logic [16:0] wet_q;

	// state
	logic [31:0]                   phase_q;
	logic signed [SAMPLE_BITS-1:0] chain_fb_q;
	logic signed [31:0]            z_mem_q [NUM_STAGES];
	logic [STAGE_BITS-1:0]         stage_q;
	logic                          out_valid_q;

	// working registers
	logic signed [SAMPLE_BITS-1:0] x_in_q;
	logic [16:0]                   u_q;
	logic signed [65:0]            prod_q;
	logic [31:0]                   d_q;
	logic signed [31:0]            x_q;
	logic signed [31:0]            y_q;
	logic [SAMPLE_BITS-1:0]        out_q;

	logic                        div_busy;
	logic [30:0]                 quot;

	logic [1:0]                  quad;
	logic [SINE_ADDR_BITS-1:0]   pos;
	logic [SINE_ADDR_BITS:0]     rom_k;
	logic [16:0]                 sine_v;
	logic [17:0]                 u_sum;
	logic signed [16:0]          sweep_diff;
	logic signed [32:0]          op_a;
	logic signed [32:0]          op_b;
	logic signed [65:0]          rnd16;
	logic signed [65:0]          rnd30;

	aph_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.d      (d_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	// LFO lookup on the phase from before this sample's increment
	assign quad  = phase_q[31:30];
	assign pos   = phase_q[29 -: SINE_ADDR_BITS];
	assign rom_k = quad[0] ? ((SINE_ADDR_BITS+1)'(SINE_DEPTH) - {1'b0, pos}) : {1'b0, pos};
	assign sine_v = rom_k[SINE_ADDR_BITS] ? 17'd65536 : SINE_ROM[rom_k[SINE_ADDR_BITS-1:0]];
	assign u_sum = quad[1] ? (18'd65536 - {1'b0, sine_v}) : (18'd65536 + {1'b0, sine_v});

	assign sweep_diff = $signed({1'b0, sweep_max_q}) - $signed({1'b0, sweep_min_q});

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_sel)
			MUL_D: begin
				op_a = 33'(sweep_diff);
				op_b = $signed(33'(u_q));
			end
			MUL_FB: begin
				op_a = 33'(chain_fb_q);
				op_b = $signed(33'(feedback_q));
			end
			MUL_AX: begin
				op_a = $signed(33'(quot));
				op_b = 33'(x_q);
			end
			MUL_AY: begin
				op_a = $signed(33'(quot));
				op_b = 33'(y_q);
			end
			MUL_WET: begin
				op_a = 33'(x_q);
				op_b = $signed(33'(wet_q));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign rnd16 = (prod_q + 66'sd32768) >>> 16;
	assign rnd30 = (prod_q + 66'sd536870912) >>> 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_min_q <= SWEEP_MIN_RST;
			sweep_max_q <= SWEEP_MAX_RST;
			lfo_step_q  <= LFO_STEP_RST;
			feedback_q  <= FEEDBACK_RST;
			wet_q       <= WET_DEPTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SWEEP_MIN: sweep_min_q <= cfg_wdata[15:0];
				CFG_SWEEP_MAX: sweep_max_q <= cfg_wdata[15:0];
				CFG_LFO_STEP:  lfo_step_q  <= cfg_wdata[31:0];
				CFG_FEEDBACK:  feedback_q  <= cfg_wdata[15:0];
				CFG_WET_DEPTH: wet_q       <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			chain_fb_q  <= '0;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_STAGES; i++) begin
				z_mem_q[i] <= '0;
			end
		end else begin
			if (cmd.accept) begin
				phase_q <= phase_q + lfo_step_q;
			end
			if (cmd.load_z) begin
				z_mem_q[stage_q] <= sat32(68'(rnd30) + 68'(x_q));
				stage_q <= (stage_q == STAGE_BITS'(NUM_STAGES - 1)) ? '0 : stage_q + 1'b1;
			end
			if (cmd.load_out) begin
				chain_fb_q  <= sat_s(68'(x_q));
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_in_q <= in_data[SAMPLE_BITS-1:0];
			u_q    <= u_sum[17:1];
		end
		if (cmd.mul_sel != MUL_NONE) begin
			prod_q <= op_a * op_b;
		end
		if (cmd.load_d) begin
			// exact, lands in [0, 2^32)
			d_q <= prod_q[31:0] + {sweep_min_q, 16'h0000};
		end
		if (cmd.load_x0) begin
			x_q <= sat32(68'(x_in_q) + 68'(rnd16));
		end
		if (cmd.load_y) begin
			y_q <= sat32(68'(z_mem_q[stage_q]) - 68'(rnd30));
		end
		if (cmd.load_z) begin
			x_q <= y_q;
		end
		if (cmd.load_out) begin
			out_q <= sat_s(68'(x_in_q) + 68'(rnd16));
		end
	end

	assign status.div_busy   = div_busy;
	assign status.last_stage = (stage_q == STAGE_BITS'(NUM_STAGES - 1));
	assign status.out_free   = ~out_valid_q | out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = TDATA_BITS'(out_q);

	`ASSERT_ALWAYS(a_stage_range, clk, arst_n, int'(stage_q) < NUM_STAGES)

endmodule

`default_nettype wire

// ----- src/aph_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aph_ctrl
	import aph_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire aph_status_t status,
	output aph_cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = S_DMUL;
			S_DMUL:    state_d = S_DSUM;
			S_DSUM:    state_d = S_DIVGO;
			S_DIVGO:   state_d = S_FBMUL;
			S_FBMUL:   state_d = S_FBSUM;
			S_FBSUM:   state_d = S_DIVWAIT;
			S_DIVWAIT: if (!status.div_busy) state_d = S_AXMUL;
			S_AXMUL:   state_d = S_Y;
			S_Y:       state_d = S_AYMUL;
			S_AYMUL:   state_d = S_Z;
			S_Z:       state_d = status.last_stage ? S_WMUL : S_Y;
			S_WMUL:    state_d = S_OUT;
			S_OUT:     if (status.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{default: '0, mul_sel: MUL_NONE};
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.accept   = in_valid;
			end
			S_DMUL:  cmd.mul_sel   = MUL_D;
			S_DSUM:  cmd.load_d    = 1'b1;
			S_DIVGO: cmd.div_start = 1'b1;
			S_FBMUL: cmd.mul_sel   = MUL_FB;
			S_FBSUM: cmd.load_x0   = 1'b1;
			S_AXMUL: cmd.mul_sel   = MUL_AX;
			S_Y:     cmd.load_y    = 1'b1;
			// a*y serves this stage's state update and the next stage's input term
			S_AYMUL: cmd.mul_sel   = MUL_AY;
			S_Z:     cmd.load_z    = 1'b1;
			S_WMUL:  cmd.mul_sel   = MUL_WET;
			S_OUT:   cmd.load_out  = status.out_free;
			default: cmd.in_ready  = 1'b0;
		endcase
	end

	`ASSERT_IMPL(a_start_idle, clk, arst_n, cmd.div_start, !status.div_busy)
	`ASSERT_IMPL(a_coef_ready, clk, arst_n, cmd.mul_sel == MUL_AX, !status.div_busy)
	`ASSERT_IMPL(a_out_room, clk, arst_n, cmd.load_out, status.out_free)

endmodule

`default_nettype wire

// ----- src/allpass_phaser.sv -----
// Six-stage allpass phaser swept by a sine LFO.
// Input stream s_*: one signed sample per request, s_tdata[SAMPLE_BITS-1:0].
// Output stream m_*: one saturated sample per input request, same packing,
// upper tdata bits zero.
// Config port: cfg_we writes cfg_wdata into register cfg_index (0 sweep_min,
// 1 sweep_max, 2 lfo_step, 3 feedback_gain, 4 wet_depth); other indexes are
// ignored. Write only while no sample is in flight.
// A new input request is taken only once the previous sample has been written to
// the output register and the control has returned to idle. The coefficient
// divider, one quotient bit per cycle, and the single shared multiplier, with
// each allpass stage stepping through the Y, AYMUL and Z states, set the pace.
// The feedback term is computed on the multiplier while the divider runs.
// Reset: LFO phase, feedback and stage memories clear, registers take their
// defaults, no result pending. No clearing pass.
// Stall: a finished result waits in the output register; the next sample is
// taken meanwhile, and processing holds only at its end if the output is still
// occupied.
`timescale 1ns / 1ps
`default_nettype none

module allpass_phaser
	import aph_pkg::*;
#(
	parameter int NUM_STAGES  = 6,
	parameter int SAMPLE_BITS = 24,
	localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [TDATA_BITS-1:0]     s_tdata,  // sample_in
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [TDATA_BITS-1:0]          m_tdata,  // sample_out
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

	aph_cmd_t    cmd;
	aph_status_t status;

	aph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	aph_datapath #(
		.NUM_STAGES  (NUM_STAGES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.TDATA_BITS  (TDATA_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	assign s_tready = cmd.in_ready;

endmodule

`default_nettype wire
